[hw/rtl/lpd_pkg.sv]
package lpd_pkg;

  // Last packet byte that carries decoded data (index, speed, four measurements)
  localparam int BODY_LAST = 19;
  localparam int MEAS_BYTES = 16;

  localparam logic [7:0] IDX_LO = 8'hA0;
  localparam logic [7:0] IDX_HI = 8'hF9;
  localparam int INVALID_BIT = 7;
  localparam logic [6:0] LAST_PNUM = 7'd89;
  localparam logic [1:0] LAST_SLOT = 2'd3;

  localparam logic STATUS_MEAS = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef struct packed {
    logic bad;
    logic [6:0] pnum;
    logic [15:0] speed;
    logic [MEAS_BYTES-1:0][7:0] meas;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;
  } pkt_desc_t;

endpackage

[hw/rtl/lidar_packet_deframer_unit.sv]
// Lidar packet deframer. Takes one byte of the lidar serial stream per cycle
// unless in_stall is high, skips bytes until one equals sync_byte, then gathers
// PACKET_BYTES bytes. A packet with an index outside A0h..F9h yields one result
// with status set; a good packet yields four measurement results, one per cycle
// while out_stall is low, each with its angle, distance, validity, intensity,
// speed and both packet counts. A finished packet goes into a two-entry
// descriptor queue and the output side drains it at one result per cycle while
// out_stall is low, so input bytes keep flowing while results wait. in_stall
// rises only when both queue entries are occupied, i.e. when the consumer of
// results holds out_stall for long. sync_byte may be written through the cfg
// channel (always ready) between packets.
module lidar_packet_deframer_unit import lpd_pkg::*; #(
  parameter int PACKET_BYTES = 22
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  sync_byte,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [8:0]  angle_deg,
  output logic [13:0] distance_mm,
  output logic        sample_valid,
  output logic [15:0] intensity,
  output logic [15:0] rpm_x64,
  output logic        last_of_packet,
  output logic        scan_end,
  output logic [31:0] good_packets,
  output logic [31:0] rejected_packets
);

  logic [7:0] start_code;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  pkt_desc_t  q_wr_data;
  pkt_desc_t  q_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= 8'd250;
    end else if (cfg_valid && cfg_ready) begin
      start_code <= sync_byte;
    end
  end

  lpd_front #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start_code(start_code),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_data    (q_wr_data)
  );

  lpd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_data(q_wr_data),
    .full   (q_full),
    .pop    (q_pop),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  lpd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_data          (q_rd_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .angle_deg       (angle_deg),
    .distance_mm     (distance_mm),
    .sample_valid    (sample_valid),
    .intensity       (intensity),
    .rpm_x64         (rpm_x64),
    .last_of_packet  (last_of_packet),
    .scan_end        (scan_end),
    .good_packets    (good_packets),
    .rejected_packets(rejected_packets)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("descriptor pushed into a full queue");

  a_bad_is_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_BAD) |-> (last_of_packet && distance_mm == '0))
    else $error("bad packet result not closing its packet");

  a_packet_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_packet) |=> out_valid)
    else $error("measurement results of one packet not back to back");

  a_scan_end_angle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scan_end) |-> (status == STATUS_MEAS && angle_deg >= 9'd356))
    else $error("end of scan on a result outside the last packet");

endmodule

[hw/rtl/lpd_front.sv]
module lpd_front import lpd_pkg::*; #(
  parameter int PACKET_BYTES = 22
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] start_code,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output logic       q_push,
  input  logic       q_full,
  output pkt_desc_t  q_data
);

  localparam int POS_W = $clog2(PACKET_BYTES);

  logic             in_packet;
  logic [POS_W-1:0] pos;
  logic [7:0]       body [1:BODY_LAST];
  logic [7:0]       body_next [1:BODY_LAST];
  logic [31:0]      good_count;
  logic [31:0]      bad_count;
  logic             accept;
  logic             done;
  logic             idx_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign done     = accept && in_packet &&
                    (({1'b0, pos} + 1'b1) == PACKET_BYTES[POS_W:0]);

  // Overlay the current byte so the packet-closing byte reaches the descriptor
  always_comb begin
    for (int k = 1; k <= BODY_LAST; k++) begin
      body_next[k] = (in_packet && pos == POS_W'(k)) ? data_byte : body[k];
    end
  end

  assign idx_ok = body[1] inside {[IDX_LO:IDX_HI]};

  always_comb begin
    q_data.bad      = !idx_ok;
    q_data.pnum     = 7'(body[1] - IDX_LO);
    q_data.speed    = {body_next[3], body_next[2]};
    for (int j = 0; j < MEAS_BYTES; j++) begin
      q_data.meas[j] = body_next[4 + j];
    end
    q_data.good_cnt = idx_ok ? good_count + 32'd1 : good_count;
    q_data.bad_cnt  = idx_ok ? bad_count : bad_count + 32'd1;
  end

  assign q_push = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet  <= 1'b0;
      pos        <= '0;
      good_count <= '0;
      bad_count  <= '0;
    end else if (accept) begin
      if (!in_packet) begin
        if (data_byte == start_code) begin
          in_packet <= 1'b1;
          pos       <= POS_W'(1);
        end
      end else if (done) begin
        in_packet  <= 1'b0;
        pos        <= '0;
        good_count <= q_data.good_cnt;
        bad_count  <= q_data.bad_cnt;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      body <= body_next;
    end
  end

endmodule

[hw/rtl/lpd_queue.sv]
module lpd_queue import lpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pkt_desc_t wr_data,
  output logic      full,
  input  logic      pop,
  output pkt_desc_t rd_data,
  output logic      empty
);

  pkt_desc_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

[hw/rtl/lpd_back.sv]
module lpd_back import lpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  pkt_desc_t   q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [8:0]  angle_deg,
  output logic [13:0] distance_mm,
  output logic        sample_valid,
  output logic [15:0] intensity,
  output logic [15:0] rpm_x64,
  output logic        last_of_packet,
  output logic        scan_end,
  output logic [31:0] good_packets,
  output logic [31:0] rejected_packets
);

  logic [1:0]  slot;
  logic        load;
  logic        last_now;
  logic [7:0]  b0, b1, b2, b3;
  logic [13:0] span_mm;

  assign load     = !q_empty && (!out_valid || !out_stall);
  assign last_now = q_data.bad || (slot == LAST_SLOT);
  assign q_pop    = load && last_now;

  always_comb begin
    b0      = q_data.meas[{slot, 2'd0}];
    b1      = q_data.meas[{slot, 2'd1}];
    b2      = q_data.meas[{slot, 2'd2}];
    b3      = q_data.meas[{slot, 2'd3}];
    span_mm = {b1[5:0], b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        slot      <= last_now ? 2'd0 : slot + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_of_packet   <= last_now;
      good_packets     <= q_data.good_cnt;
      rejected_packets <= q_data.bad_cnt;
      if (q_data.bad) begin
        status       <= STATUS_BAD;
        angle_deg    <= '0;
        distance_mm  <= '0;
        sample_valid <= 1'b0;
        intensity    <= '0;
        rpm_x64      <= '0;
        scan_end     <= 1'b0;
      end else begin
        status       <= STATUS_MEAS;
        angle_deg    <= {q_data.pnum, slot};
        distance_mm  <= span_mm;
        sample_valid <= !b1[INVALID_BIT] && (span_mm != '0);
        intensity    <= {b3, b2};
        rpm_x64      <= q_data.speed;
        scan_end     <= (q_data.pnum == LAST_PNUM);
      end
    end
  end

endmodule

[dv/lpd_result_checker.sv]
`timescale 1ns / 100ps

module lpd_result_checker import lpd_pkg::*; #(
  parameter int PACKET_BYTES = 22
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  sync_byte,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        status,
  input  logic [8:0]  angle_deg,
  input  logic [13:0] distance_mm,
  input  logic        sample_valid,
  input  logic [15:0] intensity,
  input  logic [15:0] rpm_x64,
  input  logic        last_of_packet,
  input  logic        scan_end,
  input  logic [31:0] good_packets,
  input  logic [31:0] rejected_packets,
  output int          mismatches,
  output int          outstanding,
  output int          checked,
  output int          good_seen,
  output int          bad_seen
);

  typedef struct packed {
    logic        st;
    logic [8:0]  angle;
    logic [13:0] span;
    logic        usable;
    logic [15:0] strength;
    logic [15:0] rotation;
    logic        last;
    logic        revolution;
    logic [31:0] good;
    logic [31:0] bad;
  } sample_t;

  sample_t     expected_samples[$];
  logic [7:0]  start_reg;
  logic        framing;
  int          frame_pos;
  logic [7:0]  frame [PACKET_BYTES];
  logic [31:0] good_total;
  logic [31:0] bad_total;
  int          err_count = 0;
  int          seen_count = 0;

  function automatic string describe(sample_t s);
    return $sformatf({"st=%0b ang=%0d mm=%0d ok=%0b int=%h spd=%h last=%0b scan=%0b",
                      " good=%0d bad=%0d"}, s.st, s.angle, s.span, s.usable, s.strength,
                     s.rotation, s.last, s.revolution, s.good, s.bad);
  endfunction

  // Decode a complete frame into the expected results it yields
  task automatic decode_frame();
    logic [7:0] idx;
    logic [6:0] pnum;
    sample_t    s;
    int         base;
    idx = frame[1];
    s = '0;
    if (!(idx inside {[IDX_LO:IDX_HI]})) begin
      bad_total = bad_total + 32'd1;
      s.st = STATUS_BAD;
      s.last = 1'b1;
      s.good = good_total;
      s.bad = bad_total;
      expected_samples.push_back(s);
    end else begin
      good_total = good_total + 32'd1;
      pnum = 7'(idx - IDX_LO);
      for (int slot = 0; slot < 4; slot++) begin
        base = 4 + 4 * slot;
        s.st = STATUS_MEAS;
        s.angle = {pnum, 2'(slot)};
        s.span = {frame[base + 1][5:0], frame[base]};
        s.usable = !frame[base + 1][7] && (s.span != 14'd0);
        s.strength = {frame[base + 3], frame[base + 2]};
        s.rotation = {frame[3], frame[2]};
        s.last = (slot == 3);
        s.revolution = (pnum == LAST_PNUM);
        s.good = good_total;
        s.bad = bad_total;
        expected_samples.push_back(s);
      end
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    if (!framing) begin
      if (b == start_reg) begin
        frame[0] = b;
        frame_pos = 1;
        framing = 1'b1;
      end
    end else begin
      frame[frame_pos] = b;
      frame_pos++;
      if (frame_pos >= PACKET_BYTES) begin
        framing = 1'b0;
        frame_pos = 0;
        decode_frame();
      end
    end
  endtask

  always @(posedge clk) begin
    sample_t got;
    sample_t want;
    if (rst) begin
      expected_samples.delete();
      start_reg = 8'hFA;
      framing = 1'b0;
      frame_pos = 0;
      good_total = '0;
      bad_total = '0;
    end else begin
      if (out_valid && !out_stall) begin
        got.st = status;
        got.angle = angle_deg;
        got.span = distance_mm;
        got.usable = sample_valid;
        got.strength = intensity;
        got.rotation = rpm_x64;
        got.last = last_of_packet;
        got.revolution = scan_end;
        got.good = good_packets;
        got.bad = rejected_packets;
        seen_count++;
        if (expected_samples.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result with nothing pending: %s", $realtime, describe(got));
        end else begin
          want = expected_samples.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= 10) begin
              $display("%0t: result %0d differs", $realtime, seen_count);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      // a byte taken in the same cycle as a write still sees the old start byte
      if (in_valid && !in_stall)
        absorb_byte(data_byte);
      if (cfg_valid && cfg_ready)
        start_reg = sync_byte;
    end
    mismatches <= err_count;
    outstanding <= expected_samples.size();
    checked <= seen_count;
    good_seen <= good_total;
    bad_seen <= bad_total;
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench import lpd_pkg::*;;

  localparam int PACKET_BYTES = 22;
  localparam logic [7:0] RESET_START = 8'hFA;
  localparam int PHASE_BYTES = 55;
  localparam int LONG_HOLD = 600;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  sync_byte = RESET_START;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  logic [8:0]  angle_deg;
  logic [13:0] distance_mm;
  logic        sample_valid;
  logic [15:0] intensity;
  logic [15:0] rpm_x64;
  logic        last_of_packet;
  logic        scan_end;
  logic [31:0] good_packets;
  logic [31:0] rejected_packets;

  int          mismatches;
  int          outstanding;
  int          checked;
  int          good_seen;
  int          bad_seen;

  logic        hold_off = 1'b0;
  logic [7:0]  start_now = RESET_START;
  bit          tx_quiet = 1'b0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  logic [7:0]  opening [25];

  always #5 clk = ~clk;

  lidar_packet_deframer_unit #(.PACKET_BYTES(PACKET_BYTES)) dut (.*);

  lpd_result_checker #(.PACKET_BYTES(PACKET_BYTES)) u_checker (.*);

  // Offer one byte after a random gap; hold the request until the block takes it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 24) == 0)
      tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_index();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, IDX_LO - 1));
      1: return 8'($urandom_range(IDX_HI + 1, 255));
      2: begin
        case ($urandom_range(0, 3))
          0: return IDX_LO;
          1: return IDX_HI;
          2: return IDX_LO - 8'd1;
          default: return IDX_HI + 8'd1;
        endcase
      end
      default: return 8'($urandom_range(IDX_LO, IDX_HI));
    endcase
  endfunction

  // Build a frame with random content and send its first keep bytes
  task automatic send_frame(input logic [7:0] idx, input int keep);
    logic [7:0] pkt [PACKET_BYTES];
    int base;
    pkt[0] = start_now;
    pkt[1] = idx;
    pkt[2] = 8'($urandom);
    pkt[3] = 8'($urandom);
    for (int slot = 0; slot < 4; slot++) begin
      base = 4 + 4 * slot;
      for (int k = 0; k < 4; k++)
        pkt[base + k] = 8'($urandom);
      case ($urandom_range(0, 5))
        0: begin
          pkt[base] = 8'h00;
          pkt[base + 1] = pkt[base + 1] & 8'hC0;
        end
        1: pkt[base + 1][7] = 1'b1;
        2: begin
          pkt[base] = 8'hFF;
          pkt[base + 1] = 8'h3F;
          pkt[base + 2] = 8'hFF;
          pkt[base + 3] = 8'hFF;
        end
        default: ;
      endcase
    end
    for (int k = 20; k < PACKET_BYTES; k++)
      pkt[k] = 8'($urandom);
    // start byte buried in the body must be taken as data
    if ($urandom_range(0, 6) == 0)
      pkt[$urandom_range(2, PACKET_BYTES - 1)] = start_now;
    for (int k = 0; k < keep; k++)
      send_byte(pkt[k]);
  endtask

  initial begin : result_sink
    int pause;
    bit quiet;
    bit held;
    quiet = 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 11) == 0)
        quiet = !quiet;
      if (hold_off && !held) begin
        pause = LONG_HOLD;
        held = 1'b1;
      end else begin
        pause = quiet ? 0 : $urandom_range(0, 8);
      end
      if (pause != 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still pending",
                 $realtime, STALL_LIMIT, outstanding);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] settings [5];
    logic [7:0] b;
    int phase_mark;
    int choice;
    opening = '{8'h00, 8'hFF, 8'h5A,
                RESET_START, IDX_HI, 8'hFF, 8'hFF,
                8'h00, 8'h00, 8'h00, 8'h00,
                8'hFF, 8'hBF, 8'hFF, 8'hFF,
                8'hFF, 8'h3F, 8'hFF, 8'hFF,
                RESET_START, 8'h40, 8'h34, 8'h12,
                RESET_START, 8'h00};
    settings = '{RESET_START, 8'h00, 8'hFF, 8'($urandom_range(1, 254)), RESET_START};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < 5; phase++) begin
      if (phase != 0) begin
        cfg_valid <= 1'b1;
        sync_byte <= settings[phase];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        start_now = settings[phase];
      end
      if (phase == 0) begin
        foreach (opening[k])
          send_byte(opening[k]);
      end
      phase_mark = bytes_sent;
      // back-to-back frames against a long output hold-off fill the descriptor queue
      if (phase == 2) begin
        hold_off <= 1'b1;
        tx_quiet = 1'b1;
        repeat (4) send_frame(pick_index(), PACKET_BYTES);
      end
      while (bytes_sent - phase_mark < PHASE_BYTES) begin
        choice = $urandom_range(0, 9);
        if (choice < 7) begin
          send_frame(pick_index(), PACKET_BYTES);
        end else if (choice == 7) begin
          send_frame(pick_index(), $urandom_range(1, PACKET_BYTES - 1));
        end else begin
          repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom_range(0, 255));
            if (b == start_now && $urandom_range(0, 9) != 0)
              b = ~b;
            send_byte(b);
          end
        end
      end
      // close any open frame with filler that cannot start a new one
      repeat (PACKET_BYTES) send_byte(~start_now);
      in_valid <= 1'b0;
      do @(posedge clk); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    $display("Covered %0d bytes under 5 start-byte settings, %0d results checked.",
             bytes_sent, checked);
    $display("Frames decoded: %0d good, %0d bad index; one long output hold-off.",
             good_seen, bad_seen);
    if (outstanding != 0)
      $display("%0d expected results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
